// File: hw/rtl/rsha_pkg.sv
// Package with the shared types and codes of the radial splat heat accumulator.
package rsha_pkg;

  localparam int GridWidth  = 256;
  localparam int GridHeight = 256;

  localparam logic [1:0] OpSplat = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  localparam logic [2:0] RegWidth     = 3'd0;
  localparam logic [2:0] RegHeight    = 3'd1;
  localparam logic [2:0] RegRadius    = 3'd2;
  localparam logic [2:0] RegThreshold = 3'd3;
  localparam logic [2:0] RegScale     = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
  } cmd_t;

  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  level;
    logic [31:0] peak;
  } rsp_t;

  typedef struct packed {
    logic [8:0] img_cols;
    logic [8:0] img_rows;
    logic [4:0] splat_radius;
    logic [7:0] weight_threshold;
    logic [7:0] full_scale;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the command and set up the first disc point
    logic clr_step;   // clear the addressed entry and advance the clear address
    logic pix_read;   // issue the memory read for the current disc point
    logic pix_write;  // write back the updated counter and step the disc point
    logic rd_issue;   // issue the memory read of a read command
    logic div_start;  // start the level division
    logic div_step;   // one division step
    logic respond;    // drive a result
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic disc_last;
    logic div_last;
  } sts_t;

endpackage

// File: hw/rtl/radial_splat_heat_accumulator_unit.sv
// Top level of the radial splat heat accumulator.
// Commands enter on cmd_i and are taken when start is high and busy is low.
// Op splat stamps a disc around (x, y), op read returns a pixel's count and level,
// op clear zeroes the grid and the peak, and op 3 only reports the peak.
// Every command gives one result on result_o, marked by result_valid_o for one cycle.
// The receiver cannot stall; results are simply presented for one cycle.
// Busy is already low in the cycle of the result strobe.
// A splat walks (2r+1)^2 disc points, each with a memory read state and a write state,
// then responds; the single port counter memory does one read-modify-write per point.
// A read goes through the bit-serial level divider before it responds.
// A clear zeroes the grid one memory entry per cycle, then responds.
// Op 3 goes straight to the response state.
// After reset the same clearing pass runs over the whole grid while
// busy is high; configuration writes on cfg_we_i are taken at any time and are
// used from the next command transfer on.
// Registers are written by index: width, height, radius, threshold, full scale.
module radial_splat_heat_accumulator_unit #(
  parameter int MAX_RADIUS  = 31,
  parameter int COUNT_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rsha_pkg::cmd_t cmd_i,
  output logic           result_valid_o,
  output rsha_pkg::rsp_t result_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [8:0]     cfg_data_i
);

  rsha_pkg::cfg_t cfg_q;
  rsha_pkg::ctl_t ctl;
  rsha_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_cols         <= 9'd256;
      cfg_q.img_rows         <= 9'd256;
      cfg_q.splat_radius     <= 5'd15;
      cfg_q.weight_threshold <= 8'd0;
      cfg_q.full_scale       <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsha_pkg::RegWidth:     cfg_q.img_cols         <= cfg_data_i;
        rsha_pkg::RegHeight:    cfg_q.img_rows         <= cfg_data_i;
        rsha_pkg::RegRadius:    cfg_q.splat_radius     <= cfg_data_i[4:0];
        rsha_pkg::RegThreshold: cfg_q.weight_threshold <= cfg_data_i[7:0];
        rsha_pkg::RegScale:     cfg_q.full_scale       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rsha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (cmd_i.op),
    .sts_i  (sts),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  rsha_datapath #(
    .MAX_RADIUS  (MAX_RADIUS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cmd_i          (cmd_i),
    .cfg_i          (cfg_q),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  a_no_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without command");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command transfer without busy");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe too long");
`endif

endmodule

// File: hw/rtl/rsha_ctrl.sv
// Controller state machine of the radial splat heat accumulator.
module rsha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        op_i,
  input  rsha_pkg::sts_t    sts_i,
  output logic              busy,
  output rsha_pkg::ctl_t    ctl_o
);

  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StClear = 4'd2;
  localparam logic [3:0] StPixRd = 4'd3;
  localparam logic [3:0] StPixWr = 4'd4;
  localparam logic [3:0] StRdMem = 4'd5;
  localparam logic [3:0] StRdDat = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StResp  = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      StInit: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          ctl_o.load = 1'b1;
          unique case (op_i)
            rsha_pkg::OpSplat: state_d = StPixRd;
            rsha_pkg::OpRead:  state_d = StRdMem;
            rsha_pkg::OpClear: state_d = StClear;
            default:           state_d = StResp;
          endcase
        end
      end
      StClear: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StResp;
        end
      end
      StPixRd: begin
        ctl_o.pix_read = 1'b1;
        state_d = StPixWr;
      end
      StPixWr: begin
        ctl_o.pix_write = 1'b1;
        state_d = sts_i.disc_last ? StResp : StPixRd;
      end
      StRdMem: begin
        ctl_o.rd_issue = 1'b1;
        state_d = StRdDat;
      end
      StRdDat: begin
        ctl_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StResp;
        end
      end
      StResp: begin
        ctl_o.respond = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StInit;
    endcase
  end

`ifndef SYNTHESIS
  a_resp_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.respond |=> !busy) else $error("response not followed by idle");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> state_q == StIdle)
    else $error("load outside idle");
  a_one_mem_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.clr_step, ctl_o.pix_read, ctl_o.pix_write, ctl_o.rd_issue}))
    else $error("several memory commands at once");
`endif

endmodule

// File: hw/rtl/rsha_datapath.sv
// Datapath of the radial splat heat accumulator: counter memory, disc walk and divider.
module rsha_datapath #(
  parameter int MAX_RADIUS  = 31,
  parameter int COUNT_BITS  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rsha_pkg::ctl_t  ctl_i,
  input  rsha_pkg::cmd_t  cmd_i,
  input  rsha_pkg::cfg_t  cfg_i,
  output rsha_pkg::sts_t  sts_o,
  output logic            result_valid_o,
  output rsha_pkg::rsp_t  result_o
);

  localparam int XW   = $clog2(rsha_pkg::GridWidth);
  localparam int YW   = $clog2(rsha_pkg::GridHeight);
  localparam int AW   = XW + YW;
  localparam int DEP  = rsha_pkg::GridWidth * rsha_pkg::GridHeight;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int CW   = 14;  // signed coordinate width, covers grid plus radius
  localparam int DW   = 2 * RW + 2;  // squared-distance width
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] mem_q [DEP];
  logic [COUNT_BITS-1:0] rdata_q;

  logic [AW-1:0]  clr_addr_q;
  logic [1:0]     op_q;
  logic [7:0]     cx_q, cy_q;
  logic [RW-1:0]  r_q;
  logic signed [RW+1:0] dx_q, dy_q;
  logic [COUNT_BITS-1:0] peak_q;
  logic [8:0] aw_eff, ah_eff;
  logic [8:0] w_q, h_q;
  logic [7:0] thr_q, fs_q;
  logic       pix_ok_q;
  logic [RW+1:0] wgt_q;
  logic [AW-1:0] pix_addr_q;

  // Effective radius.
  logic [RW-1:0] r_eff;
  always_comb begin
    if ({27'd0, cfg_i.splat_radius} > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(cfg_i.splat_radius);
  end
  assign aw_eff = ({23'd0, cfg_i.img_cols} > rsha_pkg::GridWidth)
                  ? 9'(rsha_pkg::GridWidth) : cfg_i.img_cols;
  assign ah_eff = ({23'd0, cfg_i.img_rows} > rsha_pkg::GridHeight)
                  ? 9'(rsha_pkg::GridHeight) : cfg_i.img_rows;

  // Current disc point evaluation.
  logic signed [CW-1:0] jx, ky;
  logic [DW-1:0] dsq;
  logic [RW+1:0] pt_dist;
  logic in_img, in_disc;
  logic [RW+1:0] wgt;
  always_comb begin
    logic [DW-1:0] t;
    logic signed [DW-1:0] dxw, dyw;
    dxw = DW'(dx_q);
    dyw = DW'(dy_q);
    jx = CW'($signed({1'b0, cx_q})) + CW'(dx_q);
    ky = CW'($signed({1'b0, cy_q})) + CW'(dy_q);
    dsq = $unsigned(dxw * dxw + dyw * dyw);
    pt_dist = '0;
    for (int i = 1; i <= MAX_RADIUS + 1; i++) begin
      t = DW'(i * i);
      if (t <= dsq) pt_dist = (RW+2)'(i);
    end
    in_img = (jx >= 0) && (ky >= 0) && (jx < CW'({1'b0, w_q})) && (ky < CW'({1'b0, h_q}));
    in_disc = pt_dist <= {2'b00, r_q};
    wgt = {2'b00, r_q} - pt_dist + (RW+2)'(2);
  end

  logic [AW-1:0] pix_addr;
  assign pix_addr = {ky[YW-1:0], jx[XW-1:0]};

  assign sts_o.disc_last = (dx_q == $signed({2'b00, r_q})) && (dy_q == $signed({2'b00, r_q}));
  assign sts_o.clr_last  = (clr_addr_q == AW'(DEP - 1));

  // Read command address.
  logic rd_in;
  assign rd_in = ({1'b0, cx_q} < w_q) && ({1'b0, cy_q} < h_q);

  // Divider state.
  logic [COUNT_BITS+8:0] rem_q;
  logic [COUNT_BITS+7:0] num_q;
  logic [7:0] quo_q;
  logic [$clog2(COUNT_BITS+9)-1:0] div_cnt_q;
  logic [COUNT_BITS-1:0] cnt_q;
  assign sts_o.div_last = (div_cnt_q == '0);

  logic [COUNT_BITS:0] sum;
  logic [COUNT_BITS-1:0] upd;
  assign sum = {1'b0, rdata_q} + (COUNT_BITS+1)'(wgt_q);
  assign upd = sum[COUNT_BITS] ? CountMax : sum[COUNT_BITS-1:0];

  logic [COUNT_BITS+8:0] rem_sh;
  assign rem_sh = {rem_q[COUNT_BITS+7:0], num_q[COUNT_BITS+7]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) mem_q[clr_addr_q] <= '0;
    if (ctl_i.pix_read || ctl_i.rd_issue) begin
      rdata_q <= mem_q[ctl_i.rd_issue ? pix_addr_q : pix_addr];
    end
    if (ctl_i.pix_write && pix_ok_q) mem_q[pix_addr_q] <= upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q     <= '0;
      peak_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= ctl_i.respond;
      if (ctl_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        peak_q     <= '0;
      end
      if (ctl_i.pix_write && pix_ok_q && upd > peak_q) peak_q <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= cmd_i.op;
      cx_q  <= cmd_i.x;
      cy_q  <= cmd_i.y;
      r_q   <= r_eff;
      w_q   <= aw_eff;
      h_q   <= ah_eff;
      thr_q <= cfg_i.weight_threshold;
      fs_q  <= cfg_i.full_scale;
      dx_q  <= -$signed({2'b00, r_eff});
      dy_q  <= -$signed({2'b00, r_eff});
      pix_addr_q <= {cmd_i.y[YW-1:0], cmd_i.x[XW-1:0]};
    end
    if (ctl_i.pix_read) begin
      pix_ok_q   <= in_img && in_disc && ({{(8-RW-2+8){1'b0}}, wgt} > 16'(thr_q));
      wgt_q      <= wgt;
      pix_addr_q <= pix_addr;
    end
    if (ctl_i.pix_write) begin
      if (dx_q == $signed({2'b00, r_q})) begin
        dx_q <= -$signed({2'b00, r_q});
        dy_q <= dy_q + (RW+2)'(1);
      end else begin
        dx_q <= dx_q + (RW+2)'(1);
      end
    end
    if (ctl_i.div_start) begin
      cnt_q     <= rd_in ? rdata_q : '0;
      num_q     <= (rd_in ? (COUNT_BITS+8)'(rdata_q) : '0) * (COUNT_BITS+8)'(fs_q);
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= ($clog2(COUNT_BITS+9))'(COUNT_BITS + 7);
    end
    if (ctl_i.div_step) begin
      num_q     <= num_q << 1;
      div_cnt_q <= div_cnt_q - 1'b1;
      if (rem_sh >= {9'd0, peak_q}) begin
        rem_q <= rem_sh - {9'd0, peak_q};
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
    if (ctl_i.respond) begin
      result_o.peak  <= 32'(peak_q);
      result_o.count <= (op_q == rsha_pkg::OpRead) ? 32'(cnt_q) : '0;
      result_o.level <= (op_q == rsha_pkg::OpRead && peak_q != '0) ? quo_q : '0;
    end
  end

`ifndef SYNTHESIS
  a_peak_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_step |=> peak_q == '0) else $error("peak not cleared");
  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.respond |=> result_valid_o) else $error("result strobe missing");
  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pix_write |=> peak_q >= $past(peak_q)) else $error("peak decreased");
`endif

endmodule
